@@ sv/mbrtu_pkg.sv @@
// Package for the Modbus RTU master frame engine.
// Holds operation, status and function codes, the job record and the CRC-16 step.
// No dependencies.
package mbrtu_pkg;

    // Input operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_BYTE  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_CRC        = 2'd1;
    localparam logic [1:0] ST_TIMEOUT    = 2'd2;
    localparam logic [1:0] ST_INCOMPLETE = 2'd3;

    // Output kind codes
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    // Modbus function codes
    localparam logic [7:0] FN_READ  = 8'h03;
    localparam logic [7:0] FN_WRITE = 8'h06;

    // Response lengths
    localparam logic [3:0] RESP_LEN_READ  = 4'd7;
    localparam logic [3:0] RESP_LEN_WRITE = 4'd8;

    // CRC-16 (reflected)
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [15:0] TIMEOUT_RESET = 16'd400;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    // Job queue between front and back
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_AW    = 2;
    localparam int JOBQ_CW    = 3;

    typedef enum logic {
        JOB_REQ = 1'b0,
        JOB_RES = 1'b1
    } job_kind_t;

    // One unit of work for the back end: a request frame or a transaction result
    typedef struct packed {
        job_kind_t   kind;
        logic        is_write;
        logic [7:0]  slave;
        logic [15:0] addr;
        logic [15:0] word;     // request data word or register count, or result value
        logic [1:0]  status;
    } job_t;

    // One byte through the CRC-16 register, bit-serial over eight steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

@@ sv/mbrtu_front.sv @@
// Front end: takes input items, tracks the response in flight and the timeout,
// and queues request and result jobs. Depends on mbrtu_pkg.
module mbrtu_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               accept,
    input  logic [1:0]         operation,
    input  logic [7:0]         slave_addr,
    input  logic [15:0]        reg_addr,
    input  logic [15:0]        reg_value,
    input  logic [7:0]         rx_byte,
    output logic               job_push,
    output mbrtu_pkg::job_t    job
);

    typedef enum logic {
        PH_IDLE,
        PH_WAIT
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic        is_write_reg, is_write_next;
    logic [3:0]  expect_reg,   expect_next;
    logic [3:0]  recv_reg,     recv_next;
    logic [15:0] crc_reg,      crc_next;
    logic [7:0]  crc_low_reg,  crc_low_next;
    logic [15:0] capt_reg,     capt_next;
    logic [15:0] wval_reg,     wval_next;
    logic [15:0] tick_reg,     tick_next;
    logic [15:0] timeout_reg,  timeout_next;

    logic [4:0]  pos_plus2;
    logic [15:0] tick_inc;
    logic        wr_cmd;

    // Item decode and state update
    always_comb
    begin
        phase_next    = phase_reg;
        is_write_next = is_write_reg;
        expect_next   = expect_reg;
        recv_next     = recv_reg;
        crc_next      = crc_reg;
        crc_low_next  = crc_low_reg;
        capt_next     = capt_reg;
        wval_next     = wval_reg;
        tick_next     = tick_reg;
        timeout_next  = cfg_we ? cfg_wdata : timeout_reg;
        job_push      = 1'b0;
        job           = '0;
        pos_plus2     = {1'b0, recv_reg} + 5'd2;
        tick_inc      = (tick_reg != mbrtu_pkg::TICK_MAX) ? tick_reg + 16'd1 : tick_reg;
        wr_cmd        = (operation == mbrtu_pkg::OP_WRITE);

        if (accept)
        begin
            unique case (operation) inside
                mbrtu_pkg::OP_READ, mbrtu_pkg::OP_WRITE:
                begin
                    // new request: any pending transaction is dropped
                    job_push      = 1'b1;
                    job.kind      = mbrtu_pkg::JOB_REQ;
                    job.is_write  = wr_cmd;
                    job.slave     = slave_addr;
                    job.addr      = reg_addr;
                    job.word      = wr_cmd ? reg_value : 16'd1;
                    phase_next    = PH_WAIT;
                    is_write_next = wr_cmd;
                    expect_next   = wr_cmd ? mbrtu_pkg::RESP_LEN_WRITE
                                           : mbrtu_pkg::RESP_LEN_READ;
                    recv_next     = 4'd0;
                    crc_next      = mbrtu_pkg::CRC_INIT;
                    crc_low_next  = 8'd0;
                    capt_next     = 16'd0;
                    wval_next     = wr_cmd ? reg_value : 16'd0;
                    tick_next     = 16'd0;
                end
                mbrtu_pkg::OP_BYTE:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (pos_plus2 < {1'b0, expect_reg})
                            crc_next = mbrtu_pkg::crc_feed(crc_reg, rx_byte);
                        else if (pos_plus2 == {1'b0, expect_reg})
                            crc_low_next = rx_byte;
                        if (recv_reg == 4'd3)
                            capt_next = {rx_byte, capt_reg[7:0]};
                        else if (recv_reg == 4'd4)
                            capt_next = {capt_reg[15:8], rx_byte};
                        recv_next = recv_reg + 4'd1;
                        // response complete: check trailing CRC
                        if (recv_next >= expect_reg)
                        begin
                            phase_next = PH_IDLE;
                            job_push   = 1'b1;
                            job.kind   = mbrtu_pkg::JOB_RES;
                            if ({rx_byte, crc_low_reg} == crc_reg)
                            begin
                                job.status = mbrtu_pkg::ST_OK;
                                job.word   = is_write_reg ? wval_reg : capt_reg;
                            end
                            else
                            begin
                                job.status = mbrtu_pkg::ST_CRC;
                            end
                        end
                    end
                end
                mbrtu_pkg::OP_TICK:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= timeout_reg)
                        begin
                            phase_next = PH_IDLE;
                            job_push   = 1'b1;
                            job.kind   = mbrtu_pkg::JOB_RES;
                            job.status = (recv_reg == 4'd0) ? mbrtu_pkg::ST_TIMEOUT
                                                            : mbrtu_pkg::ST_INCOMPLETE;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            is_write_reg <= 1'b0;
            expect_reg   <= 4'd0;
            recv_reg     <= 4'd0;
            crc_reg      <= mbrtu_pkg::CRC_INIT;
            crc_low_reg  <= 8'd0;
            capt_reg     <= 16'd0;
            wval_reg     <= 16'd0;
            tick_reg     <= 16'd0;
            timeout_reg  <= mbrtu_pkg::TIMEOUT_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            is_write_reg <= is_write_next;
            expect_reg   <= expect_next;
            recv_reg     <= recv_next;
            crc_reg      <= crc_next;
            crc_low_reg  <= crc_low_next;
            capt_reg     <= capt_next;
            wval_reg     <= wval_next;
            tick_reg     <= tick_next;
            timeout_reg  <= timeout_next;
        end
    end

endmodule

@@ sv/mbrtu_jobq.sv @@
// Short job queue between front and back ends.
// Depends on mbrtu_pkg.
module mbrtu_jobq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mbrtu_pkg::job_t    push_job,
    input  logic               pop,
    output mbrtu_pkg::job_t    head,
    output logic               full,
    output logic               empty
);

    mbrtu_pkg::job_t                 mem_reg [mbrtu_pkg::JOBQ_DEPTH];
    logic [mbrtu_pkg::JOBQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mbrtu_pkg::JOBQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mbrtu_pkg::JOBQ_CW-1:0]   count_reg,  count_next;
    logic                            do_push, do_pop;

    // Flags and pointer update
    always_comb
    begin
        full        = (count_reg == mbrtu_pkg::JOBQ_CW'(mbrtu_pkg::JOBQ_DEPTH));
        empty       = (count_reg == '0);
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
        head        = mem_reg[rd_ptr_reg];
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/mbrtu_back.sv @@
// Back end: expands request jobs into eight frame bytes with running CRC, passes
// results through, and holds the output register. Depends on mbrtu_pkg.
module mbrtu_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  mbrtu_pkg::job_t    head,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic               kind,
    output logic [7:0]         tx_byte,
    output logic               last_byte,
    output logic [1:0]         status,
    output logic [15:0]        result_value
);

    typedef enum logic {
        BK_IDLE,
        BK_SEND
    } bk_state_t;

    bk_state_t        state_reg, state_next;
    mbrtu_pkg::job_t  job_reg,   job_next;
    logic [2:0]       idx_reg,   idx_next;
    logic [15:0]      crc_reg,   crc_next;
    logic             ovalid_reg, ovalid_next;
    logic             kind_reg,  kind_next;
    logic [7:0]       tx_reg,    tx_next;
    logic             last_reg,  last_next;
    logic [1:0]       status_reg, status_next;
    logic [15:0]      value_reg, value_next;

    mbrtu_pkg::job_t  src;
    logic [2:0]       idx;
    logic [15:0]      crc_cur;
    logic [7:0]       byte_sel;
    logic             load;

    // Frame byte generation and output register control
    always_comb
    begin
        src         = (state_reg == BK_SEND) ? job_reg : head;
        idx         = (state_reg == BK_SEND) ? idx_reg : 3'd0;
        crc_cur     = (state_reg == BK_SEND) ? crc_reg : mbrtu_pkg::CRC_INIT;
        load        = ((state_reg == BK_SEND) || !q_empty) && (!ovalid_reg || pop);

        case (idx)
            3'd0:    byte_sel = src.slave;
            3'd1:    byte_sel = src.is_write ? mbrtu_pkg::FN_WRITE : mbrtu_pkg::FN_READ;
            3'd2:    byte_sel = src.addr[15:8];
            3'd3:    byte_sel = src.addr[7:0];
            3'd4:    byte_sel = src.word[15:8];
            3'd5:    byte_sel = src.word[7:0];
            3'd6:    byte_sel = crc_cur[7:0];
            default: byte_sel = crc_cur[15:8];
        endcase

        state_next  = state_reg;
        job_next    = job_reg;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        q_pop       = 1'b0;
        ovalid_next = ovalid_reg && !pop;
        kind_next   = kind_reg;
        tx_next     = tx_reg;
        last_next   = last_reg;
        status_next = status_reg;
        value_next  = value_reg;

        if (load)
        begin
            ovalid_next = 1'b1;
            if (src.kind == mbrtu_pkg::JOB_RES)
            begin
                // result passes straight through
                q_pop       = 1'b1;
                kind_next   = mbrtu_pkg::KIND_RESULT;
                tx_next     = 8'd0;
                last_next   = 1'b0;
                status_next = src.status;
                value_next  = (src.status == mbrtu_pkg::ST_OK) ? src.word : 16'd0;
            end
            else
            begin
                kind_next   = mbrtu_pkg::KIND_TX;
                tx_next     = byte_sel;
                last_next   = (idx == 3'd7);
                status_next = mbrtu_pkg::ST_OK;
                value_next  = 16'd0;
                if (idx < 3'd6)
                    crc_next = mbrtu_pkg::crc_feed(crc_cur, byte_sel);
                if (state_reg == BK_IDLE)
                begin
                    q_pop      = 1'b1;
                    job_next   = head;
                    state_next = BK_SEND;
                    idx_next   = 3'd1;
                end
                else if (idx == 3'd7)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            job_reg    <= '0;
            idx_reg    <= 3'd0;
            crc_reg    <= mbrtu_pkg::CRC_INIT;
            ovalid_reg <= 1'b0;
            kind_reg   <= 1'b0;
            tx_reg     <= 8'd0;
            last_reg   <= 1'b0;
            status_reg <= 2'd0;
            value_reg  <= 16'd0;
        end
        else
        begin
            state_reg  <= state_next;
            job_reg    <= job_next;
            idx_reg    <= idx_next;
            crc_reg    <= crc_next;
            ovalid_reg <= ovalid_next;
            kind_reg   <= kind_next;
            tx_reg     <= tx_next;
            last_reg   <= last_next;
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    assign empty        = !ovalid_reg;
    assign kind         = kind_reg;
    assign tx_byte      = tx_reg;
    assign last_byte    = last_reg;
    assign status       = status_reg;
    assign result_value = value_reg;

endmodule

@@ sv/modbus_rtu_master_frame_engine_unit.sv @@
// Top level of the Modbus RTU master frame engine.
// Depends on mbrtu_pkg, mbrtu_front, mbrtu_jobq and mbrtu_back.
//
// Channel   Handshake           Payload
// input     push / full         operation, slave_addr, reg_addr, reg_value, rx_byte
// result    empty / pop         kind, tx_byte, last_byte, status, result_value
// config    cfg_we              cfg_wdata (timeout_ticks)
//
// One input item is taken per cycle while the four-entry job queue has room.
// A request leaves as eight frame bytes, emitted by the back end one byte per
// cycle while the result port is not stalled, with a byte-wide CRC step; a result
// leaves as one item. Reset is asynchronous and leaves the block ready at once. A
// stalled result port backs up the job queue and then raises full.
module modbus_rtu_master_frame_engine_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [7:0]  slave_addr,
    input  logic [15:0] reg_addr,
    input  logic [15:0] reg_value,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [7:0]  tx_byte,
    output logic        last_byte,
    output logic [1:0]  status,
    output logic [15:0] result_value
);

    mbrtu_pkg::job_t  front_job;
    mbrtu_pkg::job_t  q_head;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic             accept;

    // Input transaction accepted
    assign accept = push && !q_full;
    assign full   = q_full;

    mbrtu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .operation  (operation),
        .slave_addr (slave_addr),
        .reg_addr   (reg_addr),
        .reg_value  (reg_value),
        .rx_byte    (rx_byte),
        .job_push   (q_push),
        .job        (front_job)
    );

    mbrtu_jobq u_jobq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    mbrtu_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .kind         (kind),
        .tx_byte      (tx_byte),
        .last_byte    (last_byte),
        .status       (status),
        .result_value (result_value)
    );

`ifndef SYNTHESIS
    // Front never queues a job into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("job pushed into full queue");

    // Back never takes from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("job popped from empty queue");

    // A result item carries no frame byte and no end-of-frame mark
    a_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == mbrtu_pkg::KIND_RESULT) |-> (tx_byte == 8'd0 && !last_byte))
        else $error("result item carries frame byte data");

    // The final frame byte is followed by a new job or an idle back end
    a_last_then_result_or_first: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && last_byte) |=> (empty || kind == mbrtu_pkg::KIND_RESULT
                                          || !last_byte))
        else $error("two end-of-frame bytes in a row");
`endif

endmodule
